[hdl/pol_pkg.sv]
package pol_pkg;

  // Operation codes carried by func.
  localparam logic [2:0] F_INS_FRONT = 3'd0;
  localparam logic [2:0] F_INS_BACK  = 3'd1;
  localparam logic [2:0] F_INS_AT    = 3'd2;
  localparam logic [2:0] F_DEL_FRONT = 3'd3;
  localparam logic [2:0] F_DEL_BACK  = 3'd4;
  localparam logic [2:0] F_DEL_AT    = 3'd5;
  localparam logic [2:0] F_DUMP      = 3'd6;

  // Status codes of a result.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_DUMP,
    S_DRAIN,
    S_FIN
  } pol_state_t;

  // Kind of multi-cycle operation in flight.
  typedef enum logic [1:0] {
    K_INS,
    K_DEL,
    K_DUMP
  } pol_kind_t;

endpackage

[hdl/pol_ram.sv]
module pol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/positional_ordered_list.sv]
// Error results, no-op results and an empty dump appear in the cycle after the item is taken.
// Insert or delete at the end of the list goes straight to the final step, which answers; one
// that moves n stored entries moves one entry per cycle through the RAM port, drains, then answers.
// Dump of c elements reads from the front and registers each element as a result, one per cycle;
// busy stays high until the last read has drained. Results cannot be stalled by the receiver.
// Synchronous reset empties the list and clears control state; the element RAM is not cleared.
module positional_ordered_list #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        func,
  input  logic signed [31:0]                item_value,
  input  logic [$clog2(CAPACITY+1)-1:0]     position,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [$clog2(CAPACITY+1)-1:0]     entry_count,
  output logic signed [31:0]                read_value,
  output logic                              last
);
  import pol_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  pol_state_t state, state_next;
  pol_kind_t  kind, kind_next;

  logic [CW-1:0] count, count_next;
  logic [AW-1:0] rptr, rptr_next;
  logic [AW-1:0] wptr, wptr_next;
  logic [AW-1:0] tgt, tgt_next;
  logic signed [31:0] val, val_next;
  logic pend, pend_next;
  logic dpend, dpend_next;
  logic dlast, dlast_next;

  logic done_next, last_next;
  logic [1:0] status_next;
  logic [CW-1:0] entry_count_next;
  logic signed [31:0] read_value_next;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  logic full, empty, ins_bad, del_bad;
  logic [CW-1:0] cnt_m1, pos_m1;
  logic [AW-1:0] last_idx, pos_idx, cnt_idx;

  pol_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Checks and indexes derived from the current count and position.
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign cnt_m1   = count - CW'(1);
  assign pos_m1   = position - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];
  assign pos_idx  = pos_m1[AW-1:0];
  assign cnt_idx  = count[AW-1:0];
  assign ins_bad  = (position == '0) ||
                    ({1'b0, position} > ({1'b0, count} + (CW+1)'(1)));
  assign del_bad  = (position == '0) || (position > count);

  assign busy = (state != S_IDLE);

  // State, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      dpend <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      dpend <= dpend_next;
      done  <= done_next;
    end
    kind        <= kind_next;
    rptr        <= rptr_next;
    wptr        <= wptr_next;
    tgt         <= tgt_next;
    val         <= val_next;
    dlast       <= dlast_next;
    status      <= status_next;
    entry_count <= entry_count_next;
    read_value  <= read_value_next;
    last        <= last_next;
  end

  // Next state, RAM control and results.
  always_comb begin
    state_next       = state;
    kind_next        = kind;
    count_next       = count;
    rptr_next        = rptr;
    wptr_next        = wptr;
    tgt_next         = tgt;
    val_next         = val;
    pend_next        = 1'b0;
    dpend_next       = 1'b0;
    dlast_next       = dlast;
    done_next        = 1'b0;
    status_next      = status;
    entry_count_next = entry_count;
    read_value_next  = read_value;
    last_next        = last;
    we               = 1'b0;
    waddr            = wptr;
    wdata            = rdata;
    raddr            = rptr;

    // A shift read issued last cycle is written back now.
    if (pend) begin
      we = 1'b1;
    end

    // A dump read issued last cycle becomes a result now.
    if (dpend) begin
      done_next        = 1'b1;
      status_next      = ST_OK;
      entry_count_next = count;
      read_value_next  = rdata;
      last_next        = dlast;
    end

    unique case (state)
      S_IDLE: begin
        if (start) begin
          // Immediate result unless a multi-cycle path is taken below.
          done_next        = 1'b1;
          status_next      = ST_OK;
          entry_count_next = count;
          read_value_next  = '0;
          last_next        = 1'b1;
          val_next         = item_value;
          unique case (func)
            F_INS_FRONT, F_INS_BACK, F_INS_AT: begin
              if (full) begin
                status_next = ST_FULL;
              end else if (func == F_INS_AT && ins_bad) begin
                status_next = ST_BADPOS;
              end else begin
                done_next = 1'b0;
                kind_next = K_INS;
                if (func == F_INS_FRONT) begin
                  tgt_next = '0;
                end else if (func == F_INS_BACK) begin
                  tgt_next = cnt_idx;
                end else begin
                  tgt_next = pos_idx;
                end
                rptr_next = last_idx;
                // Nothing to shift when the new value lands just past the last element.
                if (func == F_INS_BACK || (func == F_INS_AT && pos_m1 == count) ||
                    (func == F_INS_FRONT && empty)) begin
                  state_next = S_FIN;
                end else begin
                  state_next = S_INS;
                end
              end
            end
            F_DEL_FRONT, F_DEL_BACK, F_DEL_AT: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else if (func == F_DEL_AT && del_bad) begin
                status_next = ST_BADPOS;
              end else begin
                done_next = 1'b0;
                kind_next = K_DEL;
                if (func == F_DEL_FRONT) begin
                  tgt_next  = '0;
                  rptr_next = AW'(1);
                end else if (func == F_DEL_BACK) begin
                  tgt_next  = last_idx;
                  rptr_next = last_idx;
                end else begin
                  tgt_next  = pos_idx;
                  rptr_next = pos_idx + AW'(1);
                end
                if (func == F_DEL_BACK || (func == F_DEL_FRONT && count == CW'(1)) ||
                    (func == F_DEL_AT && position == count)) begin
                  state_next = S_FIN;
                end else begin
                  state_next = S_DEL;
                end
              end
            end
            F_DUMP: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                done_next  = 1'b0;
                kind_next  = K_DUMP;
                rptr_next  = '0;
                state_next = S_DUMP;
              end
            end
            default: begin
              status_next = ST_OK;
            end
          endcase
        end
      end
      S_INS: begin
        // Move entry rptr up by one, walking from the back toward the target.
        pend_next = 1'b1;
        wptr_next = rptr + AW'(1);
        if (rptr == tgt) begin
          state_next = S_DRAIN;
        end else begin
          rptr_next = rptr - AW'(1);
        end
      end
      S_DEL: begin
        // Move entry rptr down by one, walking from the target toward the back.
        pend_next = 1'b1;
        wptr_next = rptr - AW'(1);
        if (rptr == last_idx) begin
          state_next = S_DRAIN;
        end else begin
          rptr_next = rptr + AW'(1);
        end
      end
      S_DUMP: begin
        // Read one element a cycle from the front.
        dpend_next = 1'b1;
        dlast_next = (rptr == last_idx);
        if (rptr == last_idx) begin
          state_next = S_DRAIN;
        end else begin
          rptr_next = rptr + AW'(1);
        end
      end
      S_DRAIN: begin
        // The final pending write completes this cycle, or the final dump result is registered.
        if (kind == K_DUMP) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // Place the new value or drop the freed slot, then answer.
        if (kind == K_INS) begin
          we         = 1'b1;
          waddr      = tgt;
          wdata      = val;
          count_next = count + CW'(1);
        end else begin
          count_next = cnt_m1;
        end
        done_next        = 1'b1;
        status_next      = ST_OK;
        entry_count_next = count_next;
        read_value_next  = '0;
        last_next        = 1'b1;
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // The count never goes beyond the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  // The final write of a value never collides with a pending shift write or dump read.
  assert property (@(posedge clk) disable iff (rst) (state == S_FIN) |-> (!pend && !dpend))
    else $error("write port conflict in final step");

  // An accepted item either answers on the next cycle or keeps the block busy.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("accepted item neither answered nor in progress");

  // The count moves by at most one per item.
  assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + CW'(1) || count == $past(count) - CW'(1)))
    else $error("element count jumped");
`endif

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pol_pkg::*;

  localparam int CAP = 64;
  localparam int PW = $clog2(CAP + 1);
  // Code 7 is not an operation; the block answers it like a no-op.
  localparam logic [2:0] F_NOP = 3'd7;
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef struct packed {
    logic [1:0]         st;
    logic [PW-1:0]      cnt;
    logic signed [31:0] val;
    logic               lst;
  } outcome_t;

  // Tracks the list contents and holds the results each accepted item should cause.
  class list_tracker;
    logic signed [31:0] slots [CAP];
    int held;
    int errors;
    outcome_t expected_outcomes[$];

    function new();
      held = 0;
      errors = 0;
    endfunction

    // Print one line per mismatch (bounded so a broken block cannot flood the log).
    function void flag_error(string msg);
      if (errors < 40) begin
        $display("ERROR at %0t: %s", $time, msg);
      end
      errors++;
    endfunction

    function void expect_one(logic [1:0] st, logic signed [31:0] val, logic lst);
      outcome_t o;
      o.st = st;
      o.cnt = held[PW-1:0];
      o.val = val;
      o.lst = lst;
      expected_outcomes.push_back(o);
    endfunction

    // Apply one list operation and queue the results it should give.
    function void apply_list_op(logic [2:0] f, logic signed [31:0] v, logic [PW-1:0] p);
      int idx;
      int i;
      logic [1:0] st;
      st = ST_OK;
      case (f)
        F_INS_FRONT, F_INS_BACK, F_INS_AT: begin
          // The full check wins over a bad position.
          if (held >= CAP) begin
            st = ST_FULL;
          end else if (f == F_INS_AT && (p == 0 || int'(p) > held + 1)) begin
            st = ST_BADPOS;
          end else begin
            if (f == F_INS_FRONT) idx = 0;
            else if (f == F_INS_BACK) idx = held;
            else idx = int'(p) - 1;
            for (i = held; i > idx; i--) slots[i] = slots[i - 1];
            slots[idx] = v;
            held++;
          end
          expect_one(st, '0, 1'b1);
        end
        F_DEL_FRONT, F_DEL_BACK, F_DEL_AT: begin
          // The empty check wins over a bad position.
          if (held == 0) begin
            st = ST_EMPTY;
          end else if (f == F_DEL_AT && (p == 0 || int'(p) > held)) begin
            st = ST_BADPOS;
          end else begin
            if (f == F_DEL_FRONT) idx = 0;
            else if (f == F_DEL_BACK) idx = held - 1;
            else idx = int'(p) - 1;
            for (i = idx; i + 1 < held; i++) slots[i] = slots[i + 1];
            held--;
          end
          expect_one(st, '0, 1'b1);
        end
        F_DUMP: begin
          if (held == 0) begin
            expect_one(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < held; i++) expect_one(ST_OK, slots[i], i + 1 == held);
          end
        end
        default: begin
          expect_one(ST_OK, '0, 1'b1);
        end
      endcase
    endfunction

    // Compare one result from the block with the oldest expectation.
    function void check_result(logic [1:0] st, logic [PW-1:0] cnt, logic signed [31:0] val,
                               logic lst);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        flag_error($sformatf("unexpected result st=%0d cnt=%0d val=%0d last=%0b",
                             st, cnt, val, lst));
        return;
      end
      want = expected_outcomes.pop_front();
      if (st !== want.st || cnt !== want.cnt || val !== want.val || lst !== want.lst) begin
        flag_error($sformatf("got st=%0d cnt=%0d val=%0d last=%0b, want st=%0d cnt=%0d val=%0d last=%0b",
                             st, cnt, val, lst, want.st, want.cnt, $signed(want.val), want.lst));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [2:0] func;
  logic signed [31:0] item_value;
  logic [PW-1:0] position;
  logic done;
  logic [1:0] status;
  logic [PW-1:0] entry_count;
  logic signed [31:0] read_value;
  logic last;

  list_tracker sb = new();
  bit no_idle = 1'b0;
  int sent_count = 0;

  positional_ordered_list #(.CAPACITY(CAP)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .item_value(item_value),
    .position(position),
    .done(done),
    .status(status),
    .entry_count(entry_count),
    .read_value(read_value),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses results.
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      sb.check_result(status, entry_count, read_value, last);
    end
  end

  // Mostly short gaps, a few long ones, none at all during bursts.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  // Positions cluster around the valid range and its edges; lim is the highest valid one.
  function automatic logic [PW-1:0] pick_pos(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60 && lim >= 1) return PW'($urandom_range(1, lim));
    else if (r < 70) return '0;
    else if (r < 80) return PW'(lim + 1);
    else if (r < 90) return PW'(lim);
    else return PW'($urandom_range(0, 127));
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(logic [2:0] f, logic signed [31:0] v, logic [PW-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    item_value <= v;
    position <= p;
    do @(posedge clk); while (busy);
    sb.apply_list_op(f, v, p);
    sent_count++;
    if (sent_count % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_insert();
    logic [2:0] f;
    case ($urandom_range(0, 2))
      0: f = F_INS_FRONT;
      1: f = F_INS_BACK;
      default: f = F_INS_AT;
    endcase
    send_item(f, pick_value(), pick_pos(sb.held + 1));
  endtask

  task automatic send_delete();
    logic [2:0] f;
    case ($urandom_range(0, 2))
      0: f = F_DEL_FRONT;
      1: f = F_DEL_BACK;
      default: f = F_DEL_AT;
    endcase
    send_item(f, pick_value(), pick_pos(sb.held));
  endtask

  // Random mix; above the given size deletes become more likely than inserts.
  task automatic send_mixed(int shrink_above);
    int r;
    int ins_share;
    ins_share = (sb.held > shrink_above) ? 25 : 45;
    r = $urandom_range(0, 99);
    if (r < 5) send_item(3'($urandom_range(0, 7)), pick_value(), PW'($urandom_range(0, 127)));
    else if (r < 10) send_item(F_NOP, pick_value(), PW'($urandom_range(0, 127)));
    else if (r < 20) send_item(F_DUMP, pick_value(), PW'($urandom_range(0, 127)));
    else if (r < 20 + ins_share) send_insert();
    else send_delete();
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    func <= F_INS_FRONT;
    item_value <= '0;
    position <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, bad positions, value extremes, no-op, short dumps.
    send_item(F_DUMP, '0, '0);
    send_item(F_DEL_FRONT, '0, '0);
    send_item(F_DEL_BACK, '0, '0);
    send_item(F_DEL_AT, '0, 7'd5);
    send_item(F_INS_AT, 32'sh1234_5678, 7'd0);
    send_item(F_INS_AT, 32'sh1234_5678, 7'd2);
    send_item(F_INS_AT, 32'sh8000_0000, 7'd1);
    send_item(F_INS_FRONT, 32'sh7fff_ffff, 7'd127);
    send_item(F_INS_BACK, -32'sd1, 7'd0);
    send_item(F_INS_AT, '0, 7'd4);
    send_item(F_INS_AT, 32'sh5555_5555, 7'd2);
    send_item(F_INS_AT, 32'sh2aaa_aaaa, 7'd127);
    send_item(F_DEL_AT, '0, 7'd0);
    send_item(F_DEL_AT, '0, 7'd6);
    send_item(F_DEL_AT, '0, 7'd127);
    send_item(F_DEL_AT, '0, 7'd3);
    send_item(F_NOP, 32'shaaaa_aaaa, 7'd127);
    send_item(F_DUMP, '0, '0);
    send_item(F_DEL_AT, '0, 7'd4);
    send_item(F_DEL_FRONT, '0, '0);
    send_item(F_DEL_BACK, '0, '0);
    send_item(F_DUMP, -32'sd1, 7'd127);
    send_item(F_DEL_AT, '0, 7'd1);
    send_item(F_DUMP, '0, '0);
    send_item(F_NOP, '0, '0);
    // Insert at the front of an empty list, then empty it again.
    send_item(F_INS_FRONT, 32'sh0bad_f00d, '0);
    send_item(F_DUMP, '0, '0);
    send_item(F_DEL_FRONT, '0, '0);

    // Random traffic on a short list.
    repeat (50) send_mixed(10);

    // Grow the list to capacity with some noise.
    while (sb.held < CAP) begin
      if ($urandom_range(0, 9) == 0) send_mixed(CAP);
      else send_insert();
    end

    // Full list: full wins over position, then a full dump and edge deletes.
    send_item(F_INS_FRONT, pick_value(), '0);
    send_item(F_INS_BACK, pick_value(), '0);
    send_item(F_INS_AT, pick_value(), 7'd0);
    send_item(F_INS_AT, pick_value(), 7'd65);
    send_item(F_INS_AT, pick_value(), 7'd1);
    send_item(F_DUMP, '0, '0);
    send_item(F_DEL_AT, '0, 7'd65);
    send_item(F_DEL_AT, '0, 7'd0);
    send_item(F_DEL_AT, '0, 7'd64);

    // Drain back to empty.
    while (sb.held > 0) begin
      if ($urandom_range(0, 19) == 0) send_item(F_DUMP, '0, '0);
      else send_delete();
    end

    // A last random stretch starting from the empty list.
    repeat (40) send_mixed(40);
    start <= 1'b0;

    // Wait for every expected result, then a little longer for stray ones.
    while (sb.expected_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/pol_pkg.sv
hdl/pol_ram.sv
hdl/positional_ordered_list.sv
bench/tb_top.sv
